@@ rtl/core/sws_pkg.sv @@
`timescale 1ns / 1ps
package sws_pkg;
  localparam int WindowMax = 16;
  localparam int CntW = $clog2(WindowMax + 1);
  localparam int IdxW = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int SampleW = 16;
  localparam int SumW = SampleW + CntW;
  localparam int QDepth = 2;
  localparam int QCntW = $clog2(QDepth + 1);
  localparam int QIdxW = (QDepth > 1) ? $clog2(QDepth) : 1;

  localparam logic [1:0] ModeMean = 2'd0;
  localparam logic [1:0] ModeMin = 2'd1;
  localparam logic [1:0] ModeMax = 2'd2;
  localparam logic [1:0] ModeMedian = 2'd3;

  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegLow = 2'd1;
  localparam logic [1:0] RegHigh = 2'd2;
  localparam logic [1:0] RegLen = 2'd3;

  typedef struct packed {
    logic                ok;
    logic [SampleW-1:0]  sample;
  } job_t;
endpackage

@@ rtl/core/sws_front.sv @@
`timescale 1ns / 1ps
module sws_front import sws_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [SampleW-1:0] in_tdata,
  input  logic [SampleW-1:0] range_low,
  input  logic [SampleW-1:0] range_high,
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);
  job_t q_r [QDepth];
  logic [QIdxW-1:0] wp_r, rp_r;
  logic [QCntW-1:0] cnt_r;
  logic [SampleW-1:0] lo, hi;
  logic push, pop;

  assign lo = (range_low > range_high) ? range_high : range_low;
  assign hi = (range_low > range_high) ? range_low : range_high;
  assign in_tready = (cnt_r != QCntW'(QDepth));
  assign push = in_tvalid && in_tready;
  assign job_valid = (cnt_r != '0);
  assign pop = job_valid && job_ready;
  assign job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == QIdxW'(QDepth - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == QIdxW'(QDepth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + QCntW'(push) - QCntW'(pop);
    end
    if (push) begin
      q_r[wp_r].ok <= (in_tdata >= lo) && (in_tdata <= hi);
      q_r[wp_r].sample <= in_tdata;
    end
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= QCntW'(QDepth))
    else $error("queue overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QCntW'(QDepth)) |-> !in_tready) else $error("ready while full");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !job_valid) else $error("job from empty queue");
`endif
endmodule

@@ rtl/core/sws_back.sv @@
`timescale 1ns / 1ps
module sws_back import sws_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  job_t               job,
  input  logic [1:0]         stat_mode,
  input  logic [4:0]         window_len,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,
  output logic               out_tuser
);
  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SCAN, S_SORT, S_DIV, S_OUT} state_t;
  state_t state_r;
  logic [SampleW-1:0] win_r [WindowMax];
  logic [SampleW-1:0] srt_r [WindowMax];
  logic [CntW-1:0] fill_r, i_r, j_r;
  logic [SumW-1:0] sum_r, rem_r, quo_r;
  logic [SampleW-1:0] acc_r;
  logic valid_r;
  logic [SampleW-1:0] stat_r;
  logic [CntW-1:0] n_r;
  logic [5:0] len_raw;
  logic [CntW-1:0] len;
  logic [SumW:0] trial;
  logic [SumW-1:0] num;

  always_comb begin
    len_raw = {1'b0, window_len} | {5'd0, stat_mode == ModeMedian};
    if (len_raw == 6'd0) len = CntW'(1);
    else if (len_raw > 6'(WindowMax)) len = CntW'(WindowMax);
    else len = CntW'(len_raw);
  end

  assign job_ready = (state_r == S_IDLE) && !out_tvalid;
  assign num = rem_r;
  assign trial = {1'b0, num[SumW-2:0], quo_r[SumW-1]} - (SumW+1)'(n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_tvalid && out_tready) out_tvalid <= 1'b0;
          if (job_valid && job_ready) begin
            if (!job.ok) begin
              valid_r <= 1'b0;
              stat_r <= '0;
              n_r <= fill_r;
              out_tvalid <= 1'b1;
            end else begin
              n_r <= (fill_r >= len) ? len : fill_r + 1'b1;
              i_r <= ((fill_r >= len) ? len : fill_r + 1'b1) - 1'b1;
              acc_r <= job.sample;
              state_r <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (i_r == '0) begin
            win_r[0] <= acc_r;
            fill_r <= n_r;
            i_r <= '0;
            sum_r <= '0;
            state_r <= S_SCAN;
          end else begin
            win_r[i_r[IdxW-1:0]] <= win_r[i_r[IdxW-1:0] - 1'b1];
            i_r <= i_r - 1'b1;
          end
        end
        S_SCAN: begin
          sum_r <= sum_r + SumW'(win_r[i_r[IdxW-1:0]]);
          srt_r[i_r[IdxW-1:0]] <= win_r[i_r[IdxW-1:0]];
          if (i_r == '0) acc_r <= win_r[0];
          else if (stat_mode == ModeMin && win_r[i_r[IdxW-1:0]] < acc_r)
            acc_r <= win_r[i_r[IdxW-1:0]];
          else if (stat_mode == ModeMax && win_r[i_r[IdxW-1:0]] > acc_r)
            acc_r <= win_r[i_r[IdxW-1:0]];
          if (i_r == n_r - 1'b1) begin
            i_r <= '0;
            j_r <= '0;
            case (stat_mode)
              ModeMean: begin
                quo_r <= sum_r + SumW'(win_r[i_r[IdxW-1:0]]) + SumW'(n_r) - 1'b1;
                rem_r <= '0;
                state_r <= S_DIV;
              end
              ModeMedian: state_r <= S_SORT;
              default: state_r <= S_OUT;
            endcase
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_SORT: begin
          // odd-even transposition: n passes over adjacent pairs
          for (int k = 0; k < WindowMax - 1; k++) begin
            if (k[0] == j_r[0] && (k + 1) < int'(n_r) &&
                srt_r[k] > srt_r[k+1]) begin
              srt_r[k] <= srt_r[k+1];
              srt_r[k+1] <= srt_r[k];
            end
          end
          if (j_r == n_r) begin
            acc_r <= srt_r[IdxW'((n_r - 1'b1) >> 1)];
            state_r <= S_OUT;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_DIV: begin
          if (!trial[SumW]) rem_r <= trial[SumW-1:0];
          else rem_r <= {num[SumW-2:0], quo_r[SumW-1]};
          quo_r <= {quo_r[SumW-2:0], !trial[SumW]};
          if (j_r == CntW'(SumW - 1)) begin
            acc_r <= SampleW'({quo_r[SumW-2:0], !trial[SumW]});
            state_r <= S_OUT;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_OUT: begin
          valid_r <= 1'b1;
          stat_r <= acc_r;
          out_tvalid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {3'd0, n_r, stat_r};
  assign out_tuser = valid_r;

`ifndef SYNTH
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(WindowMax)) else $error("fill above window");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !job_ready) else $error("ready while busy");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[15:0] == '0))
    else $error("rejected word with statistic");
`endif
endmodule

@@ rtl/core/sliding_window_statistic.sv @@
`timescale 1ns / 1ps
// Sliding-window statistic: each 16-bit sample is range-checked by a front
// stage and queued; a back engine shifts it into the window and returns the
// mean (rounded up), minimum, maximum or lower median. The mean uses a
// bit-serial divider and the median an odd-even transposition sort over the
// window. out_tuser is high when the word carries a statistic and low when
// the sample was rejected.
module sliding_window_statistic import sws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // statistic, readings
  output logic        out_tuser,  // valid_res
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [1:0] mode_r;
  logic [15:0] low_r, high_r;
  logic [4:0] len_r;
  logic job_valid, job_ready;
  job_t job;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeMean;
      low_r <= '0;
      high_r <= 16'hFFFF;
      len_r <= 5'd16;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      case (cfg_paddr[3:2])
        RegMode: mode_r <= cfg_pwdata[1:0];
        RegLow: low_r <= cfg_pwdata[15:0];
        RegHigh: high_r <= cfg_pwdata[15:0];
        RegLen: len_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      RegMode: cfg_prdata = {30'd0, mode_r};
      RegLow: cfg_prdata = {16'd0, low_r};
      RegHigh: cfg_prdata = {16'd0, high_r};
      RegLen: cfg_prdata = {27'd0, len_r};
      default: cfg_prdata = '0;
    endcase
  end

  sws_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .range_low(low_r), .range_high(high_r),
    .job_valid, .job_ready, .job
  );

  sws_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .stat_mode(mode_r), .window_len(len_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import sws_pkg::*;

  typedef struct {
    logic [15:0] sample;
    bit          known;
    logic        ok;
    logic [15:0] stat;
    logic [4:0]  rd;
  } step_row_t;

  typedef struct {
    logic        ok;
    logic [15:0] stat;
    logic [4:0]  rd;
  } stat_word_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;
  logic out_tuser;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sliding_window_statistic i_dut (.*);

  logic [1:0]  mode_q;
  logic [15:0] low_q, high_q;
  logic [4:0]  len_q;
  logic [15:0] hist_q [WindowMax];
  int unsigned held_q;

  stat_word_t pending_stats[$];
  int mismatches;
  int cycle_count;
  bit in_quiet, out_quiet;
  int hold_off;
  bit hold_req;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("sliding_window_statistic regression: fail");
      $finish;
    end
  end

  function automatic stat_word_t window_statistic(logic [15:0] s);
    stat_word_t r;
    logic [15:0] lo, hi, srt [WindowMax], v;
    int unsigned len, n, i, j;
    logic [31:0] acc;
    lo = low_q;
    hi = high_q;
    if (lo > hi) begin
      lo = high_q;
      hi = low_q;
    end
    if (s < lo || s > hi) begin
      r.ok = 0;
      r.stat = 0;
      r.rd = held_q[4:0];
      return r;
    end
    len = len_q;
    if (mode_q == ModeMedian) len = len | 1;
    if (len < 1) len = 1;
    if (len > WindowMax) len = WindowMax;
    for (i = held_q; i > 0; i--)
      if (i < len && i < WindowMax) hist_q[i] = hist_q[i-1];
    hist_q[0] = s;
    held_q++;
    if (held_q > len) held_q = len;
    n = held_q;
    acc = 0;
    for (i = 0; i < n; i++) acc += hist_q[i];
    r.ok = 1;
    r.rd = n[4:0];
    case (mode_q)
      ModeMean: r.stat = 16'((acc + n - 1) / n);
      ModeMin: begin
        r.stat = hist_q[0];
        for (i = 1; i < n; i++) if (hist_q[i] < r.stat) r.stat = hist_q[i];
      end
      ModeMax: begin
        r.stat = hist_q[0];
        for (i = 1; i < n; i++) if (hist_q[i] > r.stat) r.stat = hist_q[i];
      end
      default: begin
        for (i = 0; i < n; i++) srt[i] = hist_q[i];
        for (i = 1; i < n; i++) begin
          v = srt[i];
          j = i;
          while (j > 0 && srt[j-1] > v) begin
            srt[j] = srt[j-1];
            j--;
          end
          srt[j] = v;
        end
        r.stat = srt[(n-1)/2];
      end
    endcase
    return r;
  endfunction

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      hold_off <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h user %b", out_tdata, out_tuser);
        end else begin
          stat_word_t e;
          e = pending_stats.pop_front();
          if (out_tuser !== e.ok || out_tdata[15:0] !== e.stat ||
              out_tdata[20:16] !== e.rd) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp ok=%b stat=%h rd=%0d got ok=%b stat=%h rd=%0d",
                       e.ok, e.stat, e.rd, out_tuser, out_tdata[15:0], out_tdata[20:16]);
          end
        end
      end
      if (hold_req && hold_off == 0) hold_off <= 400;
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 0;
      end else begin
        out_tready <= out_quiet ? 1'b1 : ($urandom_range(99) >= 31);
      end
    end
  end

  task automatic push_sample(logic [15:0] s, bit known = 0, logic ok = 0,
                             logic [15:0] st = 0, logic [4:0] rd = 0);
    stat_word_t e;
    while (!in_quiet && $urandom_range(99) < 31) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    e = window_statistic(s);
    if (known && (e.ok !== ok || e.stat !== st || e.rd !== rd)) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees for sample %h", s);
    end
    pending_stats.push_back(e);
    in_tvalid <= 1;
    in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      RegMode: mode_q = val[1:0];
      RegLow:  low_q = val[15:0];
      RegHigh: high_q = val[15:0];
      default: len_q = val[4:0];
    endcase
  endtask

  task automatic set_all(logic [1:0] m, logic [15:0] lo, logic [15:0] hi, logic [4:0] ln);
    drain();
    reg_write(RegMode, 32'(m));
    reg_write(RegLow, 32'(lo));
    reg_write(RegHigh, 32'(hi));
    reg_write(RegLen, 32'(ln));
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  step_row_t directed [5] = '{
    '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 5'd1},
    '{16'h0000, 1'b1, 1'b1, 16'h8000, 5'd2},
    '{16'h0001, 1'b0, 1'b0, 16'h0000, 5'd0},
    '{16'h8000, 1'b0, 1'b0, 16'h0000, 5'd0},
    '{16'h7FFF, 1'b0, 1'b0, 16'h0000, 5'd0}
  };

  initial begin
    int k, seg;
    logic [15:0] a, b;
    mismatches = 0;
    cycle_count = 0;
    in_quiet = 0;
    out_quiet = 0;
    hold_req = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    mode_q = ModeMean;
    low_q = 0;
    high_q = 16'hFFFF;
    len_q = 16;
    held_q = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed[i])
      push_sample(directed[i].sample, directed[i].known, directed[i].ok,
                  directed[i].stat, directed[i].rd);
    // swapped bounds, rejection on both sides
    set_all(ModeMin, 16'h2000, 16'h1000, 5'd16);
    push_sample(16'h0FFF, 1, 0, 0, held_q[4:0]);
    push_sample(16'h2001, 1, 0, 0, held_q[4:0]);
    push_sample(16'h1000);
    push_sample(16'h2000);
    set_all(ModeMax, 16'h0000, 16'hFFFF, 5'd0);
    push_sample(16'h1234);
    push_sample(16'h0042);
    set_all(ModeMedian, 16'h0000, 16'hFFFF, 5'd31);
    for (k = 0; k < 18; k++) push_sample(16'($urandom));
    set_all(ModeMedian, 16'h0000, 16'hFFFF, 5'd4);
    push_sample(16'h0005);
    push_sample(16'h0003);
    set_all(ModeMean, 16'h0000, 16'hFFFF, 5'd16);
    for (k = 0; k < 17; k++) push_sample(16'hFFFF);

    // receiver holds off while input keeps coming
    in_tvalid <= 0;
    hold_req <= 1;
    @(posedge clk);
    hold_req <= 0;
    for (k = 0; k < 8; k++) push_sample(16'($urandom));

    for (seg = 0; seg < 24; seg++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      if (seg % 4 == 0) begin
        a = 0;
        b = 16'hFFFF;
      end
      set_all(2'(seg % 4), a, b, 5'($urandom_range(seg % 6 == 0 ? 31 : 16)));
      in_quiet = (seg == 5);
      out_quiet = (seg == 5);
      for (k = 0; k < 78; k++) begin
        if ($urandom_range(3) == 0) push_sample(16'($urandom));
        else push_sample(a > b ? 16'($urandom_range(a, b)) : 16'($urandom_range(b, a)));
      end
    end
    in_quiet = 0;
    out_quiet = 0;
    drain();
    if (mismatches == 0) $display("sliding_window_statistic regression: pass");
    else $display("sliding_window_statistic regression: fail");
    $finish;
  end
endmodule
